// ----- hdl/mrp_pkg.sv -----
// Package: constants, witness tables and helpers for the Miller-Rabin tester.
`default_nettype none
package mrp_pkg;
    localparam int NUM_BITS_DEF = 32;
    localparam logic [31:0] LIMIT_A = 32'd1373653;
    localparam logic [31:0] LIMIT_B = 32'd9080191;
    localparam logic [31:0] LIMIT_C = 32'd25326001;

    typedef enum logic [1:0] {
        SET_A = 2'd0,
        SET_B = 2'd1,
        SET_C = 2'd2,
        SET_D = 2'd3
    } t_wset;

    function automatic t_wset pick_set(input logic [31:0] n);
        t_wset s;
        if (n < LIMIT_A) s = SET_A;
        else if (n < LIMIT_B) s = SET_B;
        else if (n < LIMIT_C) s = SET_C;
        else s = SET_D;
        return s;
    endfunction

    function automatic logic [2:0] wit_cnt(input t_wset s);
        logic [2:0] c;
        case (s)
            SET_A:   c = 3'd2;
            SET_B:   c = 3'd2;
            SET_C:   c = 3'd3;
            default: c = 3'd4;
        endcase
        return c;
    endfunction

    function automatic logic [31:0] wit_val(input t_wset s, input logic [1:0] k);
        logic [31:0] w;
        w = 32'd2;
        case (s)
            SET_A: w = (k == 2'd0) ? 32'd2 : 32'd3;
            SET_B: w = (k == 2'd0) ? 32'd31 : 32'd73;
            SET_C: begin
                case (k)
                    2'd0:    w = 32'd2;
                    2'd1:    w = 32'd3;
                    default: w = 32'd5;
                endcase
            end
            default: begin
                case (k)
                    2'd0:    w = 32'd2;
                    2'd1:    w = 32'd13;
                    2'd2:    w = 32'd23;
                    default: w = 32'd1662803;
                endcase
            end
        endcase
        return w;
    endfunction
endpackage
`default_nettype wire

// ----- hdl/mrp_if.sv -----
// Interfaces: candidate request channel and result channel.
`default_nettype none
interface mrp_cand_if;
    logic        valid;
    logic        ready;
    logic [31:0] candidate;
    modport source (output valid, output candidate, input ready);
    modport sink   (input valid, input candidate, output ready);
endinterface

interface mrp_res_if;
    logic valid;
    logic ready;
    logic is_prime;
    modport source (output valid, output is_prime, input ready);
    modport sink   (input valid, input is_prime, output ready);
endinterface
`default_nettype wire

// ----- hdl/mrp_modmul.sv -----
// Bit-serial interleaved modular multiplier: x*y mod n, one bit of x per cycle.
`default_nettype none
module mrp_modmul #(
    parameter int NUM_BITS = mrp_pkg::NUM_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [NUM_BITS-1:0] i_x,
    input  wire logic [NUM_BITS-1:0] i_y,
    input  wire logic [NUM_BITS-1:0] i_n,
    output logic                     o_done,
    output logic [NUM_BITS-1:0]      o_res
);
    import mrp_pkg::*;
    localparam int CW = $clog2(NUM_BITS + 1);

    logic                r_busy, r_done;
    logic [CW-1:0]       r_cnt;
    logic [NUM_BITS-1:0] r_xs, r_y, r_n, r_acc;
    logic [NUM_BITS+1:0] t0, t1, t2, nx;

    // y < n holds (or y == 1), so 2r+y < 3n: two conditional subtracts
    always_comb begin
        nx = {2'b00, r_n};
        t0 = {1'b0, r_acc, 1'b0} + (r_xs[NUM_BITS-1] ? {2'b00, r_y} : '0);
        t1 = (t0 >= nx) ? t0 - nx : t0;
        t2 = (t1 >= nx) ? t1 - nx : t1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NUM_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_xs  <= i_x;
            r_y   <= i_y;
            r_n   <= i_n;
            r_acc <= '0;
        end else if (r_busy) begin
            r_xs  <= {r_xs[NUM_BITS-2:0], 1'b0};
            r_acc <= t2[NUM_BITS-1:0];
        end
    end

    assign o_done = r_done;
    assign o_res  = r_acc;

    a_acc_below_n: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_acc < r_n) else $error("accumulator not reduced");
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy) else $error("start while busy");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("done longer than one cycle");
endmodule
`default_nettype wire

// ----- hdl/miller_rabin_prime_test_32.sv -----
// Top level: deterministic Miller-Rabin primality tester for 32-bit candidates.
//
//  channel  | dir | payload         | handshake
//  i_cand   | in  | candidate [31:0]| valid/ready
//  o_res    | out | is_prime        | valid/ready
//
// One candidate at a time. Each modular multiply runs in the bit-serial
// multiplier; a witness costs up to 2*NUM_BITS multiplies plus one reduction,
// and an odd candidate is tested against up to four witnesses. Trivial
// candidates (below 2, 2 itself, even) skip the multiplier.
// Synchronous active-low reset; a held result blocks the next request.
`default_nettype none
module miller_rabin_prime_test_32 #(
    parameter int NUM_BITS = mrp_pkg::NUM_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mrp_cand_if.sink  i_cand,
    mrp_res_if.source o_res
);
    import mrp_pkg::*;
    localparam int CW = $clog2(NUM_BITS + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RED  = 5'b00010,
        S_SQ   = 5'b00100,
        S_MUL  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [NUM_BITS-1:0] r_n, r_a, r_x, r_e, n_n, n_a, n_x, n_e;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic                r_dd, n_dd, r_res, n_res, r_ov, n_ov;
    t_wset               r_set, n_set;
    logic [1:0]          r_k, n_k;

    logic                mm_start, mm_done;
    logic [NUM_BITS-1:0] mm_x, mm_y, mm_n, mm_res, nm1;
    logic [31:0]         cand;

    mrp_modmul #(.NUM_BITS(NUM_BITS)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mm_start),
        .i_x(mm_x), .i_y(mm_y), .i_n(mm_n), .o_done(mm_done), .o_res(mm_res)
    );

    // the result register is held until taken, so no new request meanwhile
    assign i_cand.ready = (r_state == S_IDLE) && !r_ov;
    assign o_res.valid  = r_ov;
    assign o_res.is_prime = r_res;
    assign nm1 = r_n - 1'b1;

    always_comb begin
        logic [NUM_BITS-1:0] xv;
        logic [NUM_BITS-1:0] e_nx;
        logic [CW-1:0]       c_nx;
        logic                pass, post;
        n_state = r_state; n_n = r_n; n_a = r_a; n_x = r_x; n_e = r_e;
        n_cnt = r_cnt; n_dd = r_dd; n_res = r_res; n_ov = r_ov;
        n_set = r_set; n_k = r_k;
        mm_start = 1'b0; mm_x = r_x; mm_y = r_x; mm_n = r_n;
        cand = '0; xv = mm_res; e_nx = '0; c_nx = '0; pass = 1'b0; post = 1'b0;
        if (r_ov && o_res.ready) n_ov = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_cand.valid && !r_ov) begin
                    n_n  = i_cand.candidate[NUM_BITS-1:0];
                    cand = 32'(n_n);
                    n_set = pick_set(cand);
                    n_k  = 2'd0;
                    if (cand < 32'd2 || cand == 32'd2 || !cand[0]) begin
                        n_res   = (cand == 32'd2);
                        n_state = S_OUT;
                    end else begin
                        // witness mod n via witness*1 mod n
                        mm_start = 1'b1;
                        mm_x = NUM_BITS'(wit_val(n_set, 2'd0));
                        mm_y = NUM_BITS'(1);
                        mm_n = n_n;
                        n_state = S_RED;
                    end
                end
            end
            S_RED: begin
                if (mm_done) begin
                    if (mm_res == '0) begin
                        pass = 1'b1;
                    end else begin
                        n_a = mm_res; n_x = NUM_BITS'(1); n_e = nm1;
                        n_cnt = CW'(NUM_BITS); n_dd = 1'b0;
                        mm_start = 1'b1; mm_x = NUM_BITS'(1); mm_y = NUM_BITS'(1);
                        n_state = S_SQ;
                    end
                end
            end
            S_SQ: begin
                if (mm_done) begin
                    n_x = mm_res;
                    if (r_e[NUM_BITS-1]) begin
                        mm_start = 1'b1; mm_x = mm_res; mm_y = r_a;
                        n_state = S_MUL;
                    end else begin
                        post = 1'b1;
                    end
                end
            end
            S_MUL: begin
                if (mm_done) begin
                    n_x  = mm_res;
                    post = 1'b1;
                end
            end
            S_OUT: begin
                if (!r_ov || o_res.ready) begin
                    n_ov = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // end of one exponent bit: check for 1 / n-1 around the point a^d
        if (post) begin
            e_nx  = {r_e[NUM_BITS-2:0], 1'b0};
            c_nx  = r_cnt - 1'b1;
            n_e   = e_nx;
            n_cnt = c_nx;
            if (!r_dd) begin
                if (e_nx == '0) begin
                    n_dd = 1'b1;
                    pass = (xv == NUM_BITS'(1)) || (xv == nm1);
                end
            end else begin
                pass = (c_nx != '0) && (xv == nm1);
            end
            if (!pass) begin
                if (c_nx == '0) begin
                    n_res = 1'b0; n_state = S_OUT;
                end else begin
                    mm_start = 1'b1; mm_x = xv; mm_y = xv;
                    n_state = S_SQ;
                end
            end
        end

        if (pass) begin
            if ({1'b0, r_k} + 3'd1 == wit_cnt(r_set)) begin
                n_res = 1'b1; n_state = S_OUT;
            end else begin
                n_k = r_k + 2'd1;
                mm_start = 1'b1;
                mm_x = NUM_BITS'(wit_val(r_set, n_k));
                mm_y = NUM_BITS'(1);
                n_state = S_RED;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n <= n_n; r_a <= n_a; r_x <= n_x; r_e <= n_e; r_cnt <= n_cnt;
        r_dd <= n_dd; r_res <= n_res; r_set <= n_set; r_k <= n_k;
    end

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cand.valid && i_cand.ready) |=> r_state != S_IDLE)
        else $error("request accepted without starting");
    a_x_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQ || r_state == S_MUL) |-> r_x < r_n)
        else $error("working value not reduced");
    a_done_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mm_done |-> (r_state == S_RED || r_state == S_SQ || r_state == S_MUL))
        else $error("multiplier finished outside a work state");
endmodule
`default_nettype wire

// ----- verif/miller_rabin_prime_test_32_tb.sv -----
// Testbench for the Miller-Rabin tester: directed and random candidates checked against a predictor.
`default_nettype none
module miller_rabin_prime_test_32_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  MAX_CYCLES = 20_000_000;
    localparam int  DRAIN_CYCLES = 20;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   cycle_cnt = 0;
    int   err_cnt = 0;
    bit   prime_q[$];

    mrp_cand_if cand_ch();
    mrp_res_if  res_ch();

    miller_rabin_prime_test_32 dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cand (cand_ch.sink),
        .o_res  (res_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= MAX_CYCLES) begin
            $display("[miller_rabin_prime_test_32] ERROR");
            $finish;
        end
    end

    function automatic logic [31:0] mulmod(input logic [31:0] x, y, n);
        logic [63:0] p;
        p = {32'd0, x} * {32'd0, y};
        return 32'(p % {32'd0, n});
    endfunction

    function automatic logic [31:0] powmod(input logic [31:0] b, e, n);
        logic [31:0] acc;
        acc = 32'd1 % n;
        b = b % n;
        while (e != 0) begin
            if (e[0]) acc = mulmod(acc, b, n);
            b = mulmod(b, b, n);
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic bit witness_proves_composite(input logic [31:0] n, a, d,
                                                   input int m);
        logic [31:0] x;
        if (a % n == 0) return 1'b0;
        x = powmod(a % n, d, n);
        if (x == 1 || x == n - 1) return 1'b0;
        for (int i = 1; i < m; i++) begin
            x = mulmod(x, x, n);
            if (x == n - 1) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic bit predict_prime(input logic [31:0] n);
        logic [31:0] d;
        logic [31:0] wits[4];
        int m, cnt;
        if (n < 2) return 1'b0;
        if (n == 2) return 1'b1;
        if (!n[0]) return 1'b0;
        d = n - 1;
        m = 0;
        while (!d[0]) begin
            d = d >> 1;
            m++;
        end
        if (n < mrp_pkg::LIMIT_A) begin
            wits = '{2, 3, 0, 0}; cnt = 2;
        end else if (n < mrp_pkg::LIMIT_B) begin
            wits = '{31, 73, 0, 0}; cnt = 2;
        end else if (n < mrp_pkg::LIMIT_C) begin
            wits = '{2, 3, 5, 0}; cnt = 3;
        end else begin
            wits = '{2, 13, 23, 1662803}; cnt = 4;
        end
        for (int k = 0; k < cnt; k++)
            if (witness_proves_composite(n, wits[k], d, m)) return 1'b0;
        return 1'b1;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // result side: random stalls, check against oldest prediction
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 199) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(20, 200)) @(negedge i_clk);
            end else begin
                res_ch.ready <= ($urandom_range(0, 99) < 15) ? 1'b0 : 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (prime_q.size() == 0) begin
                $display("%0t: unexpected result is_prime=%0b", $realtime, res_ch.is_prime);
                err_cnt++;
            end else begin
                if (res_ch.is_prime !== prime_q[0]) begin
                    $display("%0t: is_prime mismatch: expected %0b actual %0b",
                             $realtime, prime_q[0], res_ch.is_prime);
                    err_cnt++;
                end
                void'(prime_q.pop_front());
            end
        end
    end

    // returns right after the accepting edge; valid stays high until a later gap or drain drops it
    task automatic send_candidate(input logic [31:0] n);
        int gap;
        gap = gap_len();
        @(negedge i_clk);
        if (gap > 0) begin
            cand_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cand_ch.candidate <= n;
        cand_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!cand_ch.ready);
        prime_q.push_back(predict_prime(n));
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        cand_ch.valid <= 1'b0;
        while (prime_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic test_special_cases();
        logic [31:0] vals[] = '{0, 1, 2, 3, 4, 5, 9, 31, 73, 1662803,
                                mrp_pkg::LIMIT_A - 1, mrp_pkg::LIMIT_A,
                                mrp_pkg::LIMIT_B - 1, mrp_pkg::LIMIT_B,
                                mrp_pkg::LIMIT_C - 1, mrp_pkg::LIMIT_C,
                                32'hFFFF_FFFF, 32'hFFFF_FFFB, 32'hFFFF_FFFE,
                                32'h8000_0000, 32'h8000_000B, 2047, 32'd3215031751,
                                25326001 * 1};
        foreach (vals[i]) send_candidate(vals[i]);
        wait_drained();
    endtask

    task automatic test_random_candidates(input int num);
        logic [31:0] n;
        int pick;
        for (int i = 0; i < num; i++) begin
            pick = $urandom_range(0, 9);
            case (pick)
                0:       n = $urandom_range(0, 100);
                1:       n = $urandom_range(0, mrp_pkg::LIMIT_A);
                2:       n = $urandom_range(mrp_pkg::LIMIT_A, mrp_pkg::LIMIT_B);
                3:       n = $urandom_range(mrp_pkg::LIMIT_B, mrp_pkg::LIMIT_C);
                default: n = $urandom | 32'd1;
            endcase
            if (pick == 9) n = $urandom;
            send_candidate(n);
            // stop sending until every pending request has completed
            if (i == num / 2) wait_drained();
        end
    endtask

    initial begin
        cand_ch.valid = 1'b0;
        cand_ch.candidate = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_special_cases();
        test_random_candidates(266);
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (err_cnt == 0)
            $display("[miller_rabin_prime_test_32] OK");
        else
            $display("[miller_rabin_prime_test_32] ERROR");
        $finish;
    end
endmodule
`default_nettype wire
